FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sorted date table.
// Each macro expects a clock named clk in scope; SDT_ASSERT also expects a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define SDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sdt_pkg.sv
// Package of the sorted date table: sizes, codes and shared types.
// Used by the interfaces, the controller and the top level.
package sdt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int DATE_W = 21;
  localparam int EC_W = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef logic [DATE_W-1:0] date_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    date_t wdata;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic   busy;
    count_t count;
  } stat_t;

  function automatic logic [EC_W-1:0] to_entry_count(input count_t c);
    logic [CNT_W+EC_W-1:0] wide;
    wide = {{EC_W{1'b0}}, c};
    return wide[EC_W-1:0];
  endfunction

endpackage

FILE: rtl/sdt_in_if.sv
// Request channel of the sorted date table: opcode and date of one item.
// Depends on sdt_pkg.
interface sdt_in_if import sdt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [4:0] day;
  logic [3:0] month;
  logic [11:0] year;

  modport source(output valid, opcode, day, month, year, input ready);
  modport sink(input valid, opcode, day, month, year, output ready);
endinterface

FILE: rtl/sdt_out_if.sv
// Response channel of the sorted date table: status and entry count.
// Depends on sdt_pkg.
interface sdt_out_if import sdt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [EC_W-1:0] entry_count;

  modport source(output valid, status, entry_count, input ready);
  modport sink(input valid, status, entry_count, output ready);
endinterface

FILE: rtl/sdt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                   wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                   rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/sdt_ctrl.sv
// Controller of the sorted date table: insert by shifting from the top, search by scan.
// Depends on sdt_pkg, sdt_in_if and sdt_out_if; drives the date RAM.
module sdt_ctrl import sdt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sdt_in_if.sink    req,
  sdt_out_if.source rsp,
  output mem_req_t  mreq,
  input  date_t     rdata,
  output stat_t     stat
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_SRCH = 5'b00100,
    S_KEYW = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t          state, state_next;
  count_t          count, count_next;
  date_t           key, key_next;
  addr_t           pos, pos_next;
  addr_t           idx, idx_next;
  logic [1:0]      res, res_next;
  logic            ovalid, ovalid_next;
  logic [1:0]      ostatus, ostatus_next;
  logic [EC_W-1:0] ocount, ocount_next;
  date_t           in_key;
  count_t          count_m1;

  assign in_key = {req.year, req.month, req.day};
  assign count_m1 = count - 1'b1;

  always_comb begin
    state_next = state;
    count_next = count;
    key_next = key;
    pos_next = pos;
    idx_next = idx;
    res_next = res;
    ovalid_next = ovalid;
    ostatus_next = ostatus;
    ocount_next = ocount;
    mreq.we = 1'b0;
    mreq.waddr = pos;
    mreq.wdata = key;
    mreq.raddr = '0;
    req.ready = (state == S_IDLE);

    if (ovalid && rsp.ready) begin
      ovalid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          key_next = in_key;
          if (req.opcode == OP_INSERT) begin
            if (count == CNT_W'(TABLE_DEPTH)) begin
              res_next = ST_FULL;
              state_next = S_RESP;
            end else if (count == '0) begin
              mreq.we = 1'b1;
              mreq.waddr = '0;
              mreq.wdata = in_key;
              count_next = count + 1'b1;
              res_next = ST_INSERTED;
              state_next = S_RESP;
            end else begin
              mreq.raddr = count_m1[ADDR_W-1:0];
              pos_next = count[ADDR_W-1:0];
              state_next = S_INS;
            end
          end else begin
            if (count == '0) begin
              res_next = ST_NOT_FOUND;
              state_next = S_RESP;
            end else begin
              mreq.raddr = '0;
              idx_next = '0;
              state_next = S_SRCH;
            end
          end
        end
      end
      S_INS: begin
        mreq.we = 1'b1;
        mreq.waddr = pos;
        if (rdata > key) begin
          mreq.wdata = rdata;
          mreq.raddr = pos - 1'b1 - 1'b1;
          pos_next = pos - 1'b1;
          if (pos == ADDR_W'(1)) begin
            state_next = S_KEYW;
          end
        end else begin
          mreq.wdata = key;
          count_next = count + 1'b1;
          res_next = ST_INSERTED;
          state_next = S_RESP;
        end
      end
      S_KEYW: begin
        mreq.we = 1'b1;
        mreq.waddr = '0;
        mreq.wdata = key;
        count_next = count + 1'b1;
        res_next = ST_INSERTED;
        state_next = S_RESP;
      end
      S_SRCH: begin
        if (rdata == key) begin
          res_next = ST_FOUND;
          state_next = S_RESP;
        end else if (CNT_W'(idx) == count_m1) begin
          res_next = ST_NOT_FOUND;
          state_next = S_RESP;
        end else begin
          idx_next = idx + 1'b1;
          mreq.raddr = idx + 1'b1;
        end
      end
      S_RESP: begin
        if (!ovalid || rsp.ready) begin
          ovalid_next = 1'b1;
          ostatus_next = res;
          ocount_next = to_entry_count(count);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovalid <= ovalid_next;
    end
    key <= key_next;
    pos <= pos_next;
    idx <= idx_next;
    res <= res_next;
    ostatus <= ostatus_next;
    ocount <= ocount_next;
  end

  assign rsp.valid = ovalid;
  assign rsp.status = ostatus;
  assign rsp.entry_count = ocount;
  assign stat.busy = (state != S_IDLE);
  assign stat.count = count;
endmodule

FILE: rtl/sorted_date_table_top.sv
// Top level of the sorted date table: controller and the date RAM.
// Depends on sdt_pkg, the channel interfaces, sdt_ram, sdt_ctrl and assert_macros.svh.
//
// Holds up to TABLE_DEPTH dates (year, month, day) in ascending order in one
// RAM with a registered read. One item is handled at a time and gives one
// response. An insert into a table of n dates, n at least one, walks down
// from the top, one entry per cycle, moving each later date up by one. A
// search of n dates, n at least one, scans from the bottom, one entry per
// cycle. An insert into an empty table, a refused insert into a full table
// and a search of an empty table go straight to the response. The rate is
// set by the single read port of the date RAM. The response waits in an
// output register until it is taken.
`include "assert_macros.svh"

module sorted_date_table_top import sdt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sdt_in_if.sink    req,
  sdt_out_if.source rsp
);
  mem_req_t mreq;
  date_t    rdata;
  stat_t    stat;

  sdt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .mreq  (mreq),
    .rdata (rdata),
    .stat  (stat)
  );

  sdt_ram #(
    .WIDTH (DATE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .raddr (mreq.raddr),
    .rdata (rdata)
  );

  `SDT_ASSERT(a_count_bound, stat.count <= CNT_W'(TABLE_DEPTH), "count above depth")
  `SDT_ASSERT(a_busy_after_accept, req.valid && req.ready |=> !req.ready, "accepted while busy")
  `SDT_ASSERT(a_write_in_range, mreq.we |-> CNT_W'(mreq.waddr) <= stat.count, "write past count")
  `SDT_ASSERT(a_full_no_write, !stat.busy && stat.count == CNT_W'(TABLE_DEPTH) |-> !mreq.we, "write into full table")
endmodule

FILE: dv/testbench.sv
// Self-checking testbench of sorted_date_table_top: inserts and searches of dates
// checked against an in-bench model of the sorted table. Uses sdt_pkg and the
// request and response channel interfaces of the RTL.
module testbench;
  import sdt_pkg::*;

  typedef struct {
    logic        opcode;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    bit          drain_first;
  } date_req_t;

  typedef struct {
    logic [1:0]      status;
    logic [EC_W-1:0] entry_count;
  } table_resp_t;

  logic clk;
  logic rst;

  sdt_in_if  req_if ();
  sdt_out_if rsp_if ();

  sorted_date_table_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  date_req_t   pending_reqs[$];
  table_resp_t expected_resps[$];
  date_t       stored_dates[$];
  date_t       issued_dates[$];
  int          error_count;
  int          accepted_reqs;
  int          quiet_cycles;
  wire         calm_stretch = accepted_reqs >= 700 && accepted_reqs < 950;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  function automatic void predict_table_response(input date_req_t it);
    date_t       key;
    table_resp_t resp;
    int          pos;
    key = {it.year, it.month, it.day};
    if (it.opcode == OP_INSERT) begin
      if (stored_dates.size() >= TABLE_DEPTH) begin
        resp.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < stored_dates.size() && stored_dates[pos] <= key) pos++;
        stored_dates.insert(pos, key);
        resp.status = ST_INSERTED;
      end
    end else begin
      resp.status = ST_NOT_FOUND;
      foreach (stored_dates[i]) begin
        if (stored_dates[i] == key) resp.status = ST_FOUND;
      end
    end
    resp.entry_count = EC_W'(stored_dates.size());
    expected_resps.push_back(resp);
  endfunction

  function automatic void queue_req(input logic op, input logic [11:0] year,
                                    input logic [3:0] month, input logic [4:0] day,
                                    input bit drain);
    date_req_t it;
    it.opcode = op;
    it.year = year;
    it.month = month;
    it.day = day;
    it.drain_first = drain;
    pending_reqs.push_back(it);
    if (op == OP_INSERT && issued_dates.size() < TABLE_DEPTH) begin
      issued_dates.push_back({year, month, day});
    end
  endfunction

  function automatic date_t random_date();
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    year = ($urandom_range(99) < 70) ? 12'(2000 + $urandom_range(3)) : 12'($urandom_range(4095));
    month = ($urandom_range(99) < 10) ? 4'($urandom_range(15)) : 4'($urandom_range(12, 1));
    day = ($urandom_range(99) < 10) ? 5'($urandom_range(31)) : 5'($urandom_range(31, 1));
    return {year, month, day};
  endfunction

  function automatic date_t known_date(input bit shifted);
    date_t d;
    d = issued_dates[$urandom_range(issued_dates.size() - 1)];
    if (shifted) d[4:0] = d[4:0] + 5'd1;
    return d;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.opcode = OP_INSERT;
    req_if.day = '0;
    req_if.month = '0;
    req_if.year = '0;
    rsp_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin : drive_requests
    date_req_t it;
    bit        idle;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        it.opcode = req_if.opcode;
        it.day = req_if.day;
        it.month = req_if.month;
        it.year = req_if.year;
        predict_table_response(it);
        accepted_reqs++;
      end
      if (!req_if.valid || req_if.ready) begin
        idle = !calm_stretch && $urandom_range(99) < 37;
        if (pending_reqs.size() != 0 && !idle &&
            !(pending_reqs[0].drain_first && expected_resps.size() != 0)) begin
          it = pending_reqs.pop_front();
          req_if.opcode <= it.opcode;
          req_if.day <= it.day;
          req_if.month <= it.month;
          req_if.year <= it.year;
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_responses
    table_resp_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_resps.size() == 0) begin
          report("response arrived with no item outstanding");
        end else begin
          want = expected_resps.pop_front();
          if (rsp_if.status !== want.status) begin
            report($sformatf("status %0d, expected %0d", rsp_if.status, want.status));
          end
          if (rsp_if.entry_count !== want.entry_count) begin
            report($sformatf("entry_count %0d, expected %0d",
                             rsp_if.entry_count, want.entry_count));
          end
        end
      end
      rsp_if.ready <= calm_stretch || $urandom_range(99) >= 37;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 5000) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    date_t d;
    int    pick;
    error_count = 0;
    accepted_reqs = 0;
    quiet_cycles = 0;

    // Directed part: empty table, extremes of every field, duplicates and neighbors.
    queue_req(OP_SEARCH, 12'd2000, 4'd1, 5'd1, 1'b0);
    queue_req(OP_INSERT, 12'd2000, 4'd6, 5'd15, 1'b0);
    queue_req(OP_INSERT, 12'd2000, 4'd6, 5'd15, 1'b0);
    queue_req(OP_INSERT, 12'd0, 4'd0, 5'd0, 1'b0);
    queue_req(OP_INSERT, 12'd4095, 4'd15, 5'd31, 1'b0);
    queue_req(OP_INSERT, 12'd2000, 4'd6, 5'd14, 1'b0);
    queue_req(OP_INSERT, 12'd2000, 4'd6, 5'd16, 1'b0);
    queue_req(OP_INSERT, 12'd0, 4'd1, 5'd1, 1'b0);
    queue_req(OP_SEARCH, 12'd2000, 4'd6, 5'd15, 1'b0);
    queue_req(OP_SEARCH, 12'd0, 4'd0, 5'd0, 1'b0);
    queue_req(OP_SEARCH, 12'd4095, 4'd15, 5'd31, 1'b0);
    queue_req(OP_SEARCH, 12'd4095, 4'd15, 5'd30, 1'b0);
    queue_req(OP_SEARCH, 12'd2000, 4'd13, 5'd0, 1'b0);
    queue_req(OP_INSERT, 12'd2000, 4'd13, 5'd0, 1'b1);
    queue_req(OP_SEARCH, 12'd2000, 4'd13, 5'd0, 1'b0);
    queue_req(OP_INSERT, 12'd1, 4'd12, 5'd31, 1'b0);
    queue_req(OP_INSERT, 12'd2047, 4'd8, 5'd16, 1'b0);
    queue_req(OP_SEARCH, 12'd2047, 4'd8, 5'd16, 1'b0);
    queue_req(OP_SEARCH, 12'd2048, 4'd7, 5'd15, 1'b0);

    // Random part: the table fills slowly, then stays full for the rest of the run.
    for (int i = 0; i < 1850; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        d = ($urandom_range(1) == 0) ? known_date($urandom_range(1) == 1) : random_date();
        queue_req(OP_INSERT, d[20:9], d[8:5], d[4:0], i % 300 == 150);
      end else if (pick < 66) begin
        d = known_date($urandom_range(3) == 0);
        queue_req(OP_SEARCH, d[20:9], d[8:5], d[4:0], i % 300 == 150);
      end else begin
        d = random_date();
        queue_req(OP_SEARCH, d[20:9], d[8:5], d[4:0], i % 300 == 150);
      end
    end

    @(negedge rst);
    while (pending_reqs.size() != 0 || req_if.valid || expected_resps.size() != 0) begin
      @(posedge clk);
    end
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (expected_resps.size() != 0) begin
      report($sformatf("%0d responses never arrived", expected_resps.size()));
    end
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
